// ===== sv/cmyk_pkg.sv =====
// ----------------------------------------------------------------------------
// cmyk_pkg
// constants, lane types and lookup tables for the cmyk/rgb pixel converter
// ----------------------------------------------------------------------------
package cmyk_pkg;

  localparam int unsigned LANES     = 3;
  localparam int unsigned RCP_SHIFT = 23;

  localparam logic [6:0]  PCT_FULL  = 7'd100;
  localparam logic [14:0] FIX_FULL  = 15'd25600;
  localparam logic [13:0] CMYK_DIV  = 14'd10000;
  localparam logic [23:0] CMYK_RCP  = 24'((64'(1) << RCP_SHIFT) / 10000);

  localparam logic REQ_CMYK_TO_RGB = 1'b0;
  localparam logic REQ_RGB_TO_CMYK = 1'b1;

  typedef logic [6:0]  pct_t;
  typedef logic [7:0]  byte_t;
  typedef logic [14:0] fix_t;
  typedef logic [22:0] num_t;
  typedef logic [23:0] rcp_t;
  typedef logic [13:0] dvs_t;

  typedef rcp_t rcp_tab_t [256];
  typedef fix_t blk_tab_t [256];

  // shift and subtract quotient, only used to build the tables
  function automatic logic [31:0] table_quot(logic [31:0] num, logic [31:0] den);
    logic [31:0] q;
    logic [32:0] r;
    q = '0;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      r = {r[31:0], num[i]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // floor(2^23 / max), zero for a black pixel
  function automatic rcp_tab_t make_rcp_tab();
    rcp_tab_t t;
    t[0] = '0;
    for (int i = 1; i < 256; i++) begin
      t[i] = 24'(table_quot(32'(1) << RCP_SHIFT, 32'(i)));
    end
    return t;
  endfunction

  // floor((255 - max) * 25600 / 255)
  function automatic blk_tab_t make_blk_tab();
    blk_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 15'(table_quot(32'((255 - i) * 25600), 32'd255));
    end
    return t;
  endfunction

  localparam rcp_tab_t RCP_TAB = make_rcp_tab();
  localparam blk_tab_t BLK_TAB = make_blk_tab();

endpackage

// ===== sv/cmyk_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// cmyk_rgb_converter
// five-stage pipeline from input beat to output beat
// throughput one beat per cycle while m_axis_tready does not stall it, with its own multiplier lane
// per channel (reciprocal multiply, back-multiply, remainder correction)
// each stage has its own valid bit and takes a beat as soon as it is free
// rst clears all valid bits, payload registers are not reset
// ----------------------------------------------------------------------------
module cmyk_rgb_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cyan, magenta, yellow, black, red, green, blue (8 bits each)
  input  logic [55:0] s_axis_tdata,
  // req_type
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red, green, blue (8 bits), cyan, magenta, yellow, black (15 bits), zero pad
  output logic [87:0] m_axis_tdata
);

  // stage valid bits and ready chain
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5 || m_axis_tready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // stage 1: saturate inks, find max of rgb
  logic                 typ1;
  cmyk_pkg::pct_t       ink1 [4];
  cmyk_pkg::byte_t      ch1  [cmyk_pkg::LANES];
  cmyk_pkg::byte_t      mx1;
  cmyk_pkg::pct_t       ink1_next [4];
  cmyk_pkg::byte_t      mx1_next;

  always_comb begin
    cmyk_pkg::byte_t pct;
    cmyk_pkg::byte_t r;
    cmyk_pkg::byte_t g;
    cmyk_pkg::byte_t b;
    for (int i = 0; i < 4; i++) begin
      pct = s_axis_tdata[i*8 +: 8];
      ink1_next[i] = (pct > 8'(cmyk_pkg::PCT_FULL)) ? 7'd0 : 7'(cmyk_pkg::PCT_FULL - pct[6:0]);
    end
    r = s_axis_tdata[39:32];
    g = s_axis_tdata[47:40];
    b = s_axis_tdata[55:48];
    mx1_next = r;
    if (g > mx1_next) mx1_next = g;
    if (b > mx1_next) mx1_next = b;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      typ1 <= s_axis_tuser[0];
      for (int i = 0; i < 4; i++) ink1[i] <= ink1_next[i];
      for (int i = 0; i < cmyk_pkg::LANES; i++) ch1[i] <= s_axis_tdata[32 + i*8 +: 8];
      mx1 <= mx1_next;
    end
  end

  // stage 2: numerators per lane, one divisor and reciprocal shared by all lanes
  logic                 typ2, zero2;
  cmyk_pkg::fix_t       blk2;
  cmyk_pkg::num_t       num2 [cmyk_pkg::LANES];
  cmyk_pkg::rcp_t       rcp2;
  cmyk_pkg::dvs_t       dvs2;
  cmyk_pkg::num_t       num2_next [cmyk_pkg::LANES];

  always_comb begin
    logic [13:0]     prod;
    cmyk_pkg::byte_t d;
    for (int i = 0; i < cmyk_pkg::LANES; i++) begin
      prod = 14'(ink1[i]) * 14'(ink1[3]);
      d    = mx1 - ch1[i];
      if (typ1 == cmyk_pkg::REQ_RGB_TO_CMYK) begin
        num2_next[i] = 23'(d) * 23'(cmyk_pkg::FIX_FULL);
      end else begin
        num2_next[i] = (23'(prod) << 8) - 23'(prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      typ2  <= typ1;
      zero2 <= (mx1 == 8'd0);
      blk2  <= cmyk_pkg::BLK_TAB[mx1];
      for (int i = 0; i < cmyk_pkg::LANES; i++) num2[i] <= num2_next[i];
      rcp2  <= (typ1 == cmyk_pkg::REQ_RGB_TO_CMYK) ? cmyk_pkg::RCP_TAB[mx1] : cmyk_pkg::CMYK_RCP;
      dvs2  <= (typ1 == cmyk_pkg::REQ_RGB_TO_CMYK) ? 14'(mx1) : cmyk_pkg::CMYK_DIV;
    end
  end

  // stage 3: estimate quotient by reciprocal multiply
  logic                 typ3, zero3;
  cmyk_pkg::fix_t       blk3;
  cmyk_pkg::num_t       num3 [cmyk_pkg::LANES];
  cmyk_pkg::fix_t       q3   [cmyk_pkg::LANES];
  cmyk_pkg::dvs_t       dvs3;
  logic [46:0]          est [cmyk_pkg::LANES];

  always_comb begin
    for (int i = 0; i < cmyk_pkg::LANES; i++) begin
      est[i] = 47'(num2[i]) * 47'(rcp2);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      typ3  <= typ2;
      zero3 <= zero2;
      blk3  <= blk2;
      dvs3  <= dvs2;
      for (int i = 0; i < cmyk_pkg::LANES; i++) begin
        num3[i] <= num2[i];
        q3[i]   <= est[i][cmyk_pkg::RCP_SHIFT +: 15];
      end
    end
  end

  // stage 4: multiply estimate back by divisor
  logic                 typ4, zero4;
  cmyk_pkg::fix_t       blk4;
  cmyk_pkg::num_t       num4  [cmyk_pkg::LANES];
  cmyk_pkg::num_t       back4 [cmyk_pkg::LANES];
  cmyk_pkg::fix_t       q4    [cmyk_pkg::LANES];
  cmyk_pkg::dvs_t       dvs4;
  logic [28:0]          back [cmyk_pkg::LANES];

  always_comb begin
    for (int i = 0; i < cmyk_pkg::LANES; i++) begin
      back[i] = 29'(q3[i]) * 29'(dvs3);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      typ4  <= typ3;
      zero4 <= zero3;
      blk4  <= blk3;
      dvs4  <= dvs3;
      for (int i = 0; i < cmyk_pkg::LANES; i++) begin
        num4[i]  <= num3[i];
        back4[i] <= back[i][22:0];
        q4[i]    <= q3[i];
      end
    end
  end

  // stage 5: remainder correction and output beat
  cmyk_pkg::fix_t q5 [cmyk_pkg::LANES];
  logic           typ5, zero5;
  cmyk_pkg::fix_t blk5;
  cmyk_pkg::fix_t q5_next [cmyk_pkg::LANES];

  always_comb begin
    cmyk_pkg::num_t rem;
    for (int i = 0; i < cmyk_pkg::LANES; i++) begin
      rem = num4[i] - back4[i];
      q5_next[i] = q4[i] + 15'(rem >= 23'(dvs4));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      typ5  <= typ4;
      zero5 <= zero4;
      blk5  <= blk4;
      for (int i = 0; i < cmyk_pkg::LANES; i++) q5[i] <= q5_next[i];
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    if (typ5 == cmyk_pkg::REQ_CMYK_TO_RGB) begin
      m_axis_tdata[7:0]   = q5[0][7:0];
      m_axis_tdata[15:8]  = q5[1][7:0];
      m_axis_tdata[23:16] = q5[2][7:0];
    end else begin
      if (!zero5) begin
        m_axis_tdata[38:24] = q5[0];
        m_axis_tdata[53:39] = q5[1];
        m_axis_tdata[68:54] = q5[2];
      end
      m_axis_tdata[83:69] = blk5;
    end
  end

endmodule
